>>> rtl/tds_pkg.sv
package tds_pkg;

  localparam int unsigned THR_W       = 10;
  localparam int unsigned INTERVAL_W  = 27;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned ECHO_W      = 16;
  localparam int unsigned OPEN_W      = 9;
  localparam int unsigned SCALED_W    = 24;
  localparam int unsigned CFG_DATA_W  = 27;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam int unsigned ECHO_SCALE = 165;
  localparam int unsigned DIST_DIV   = 10000;

  localparam logic [OPEN_W-1:0] OPEN_LOW_MS    = 9'd150;
  localparam logic [OPEN_W-1:0] OPEN_MEDIUM_MS = 9'd350;
  localparam logic [OPEN_W-1:0] OPEN_HIGH_MS   = 9'd500;

  localparam logic [THR_W-1:0]      THRESHOLD_RESET   = 10'd7;
  localparam logic [INTERVAL_W-1:0] IVL_LONG_RESET    = 27'd20000;
  localparam logic [INTERVAL_W-1:0] IVL_MID_RESET     = 27'd10000;
  localparam logic [INTERVAL_W-1:0] IVL_SHORT_RESET   = 27'd5000;
  localparam logic [INTERVAL_W-1:0] LEVEL_CHECK_RESET = 27'd10000;
  localparam logic [INTERVAL_W-1:0] ALARM_WAIT_RESET  = 27'd10000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEVEL_THRESHOLD = 3'd0,
    REG_IVL_LONG        = 3'd1,
    REG_IVL_MID         = 3'd2,
    REG_IVL_SHORT       = 3'd3,
    REG_LEVEL_CHECK     = 3'd4,
    REG_ALARM_WAIT      = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_ONE   = 2'd1,
    MODE_TWO   = 2'd2,
    MODE_THREE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_MANUAL = 2'd1,
    CAUSE_SCHED  = 2'd2
  } cause_t;

  // Periods are held already forced to at least one; the threshold is held
  // pre-multiplied by the distance divisor.
  typedef struct packed {
    logic [SCALED_W-1:0]   threshold_scaled;
    logic [INTERVAL_W-1:0] ivl_long;
    logic [INTERVAL_W-1:0] ivl_mid;
    logic [INTERVAL_W-1:0] ivl_short;
    logic [INTERVAL_W-1:0] level_check;
    logic [INTERVAL_W-1:0] alarm_wait;
  } cfg_t;

  typedef struct packed {
    logic                timer_a;
    logic                timer_c;
    logic                qty_a;
    logic                qty_c;
    logic                touch;
    logic [SCALED_W-1:0] echo_scaled;
  } item_t;

  function automatic logic [INTERVAL_W-1:0] at_least_one(input logic [INTERVAL_W-1:0] v);
    return (v == '0) ? INTERVAL_W'(1) : v;
  endfunction

endpackage

>>> rtl/timed_dispense_scheduler_top.sv
// Timed dispense scheduler: one request on the input channel is one
// millisecond tick of switch, touch key and echo readings, and produces
// exactly one result request on the output channel.
// Both channels use valid and ready; configuration is written through
// cfg_we, cfg_index and cfg_data. The user must write it only while the
// block is idle; the block itself does not enforce this.
// The echo time is scaled as the input register loads, and the
// scheduling logic fills the result register from it, raising
// out_valid.
// Throughput is one request per cycle while out_ready stays high, set by
// the single pass from the input register to the result register.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready falls only when both are occupied.
// Synchronous reset restores the default register values, selects the
// longest interval and lowest quantity, clears all timers and the alarm,
// and empties both registers.
module timed_dispense_scheduler_top #(
  parameter logic [tds_pkg::OPEN_W-1:0] OPEN_LOW_MS    = tds_pkg::OPEN_LOW_MS,
  parameter logic [tds_pkg::OPEN_W-1:0] OPEN_MEDIUM_MS = tds_pkg::OPEN_MEDIUM_MS,
  parameter logic [tds_pkg::OPEN_W-1:0] OPEN_HIGH_MS   = tds_pkg::OPEN_HIGH_MS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tds_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tds_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             timer_sw_a,
  input  logic                             timer_sw_c,
  input  logic                             qty_sw_a,
  input  logic                             qty_sw_c,
  input  logic                             touch_one,
  input  logic                             touch_two,
  input  logic [tds_pkg::ECHO_W-1:0]       echo_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       dispense_cause,
  output logic [tds_pkg::OPEN_W-1:0]       open_ms,
  output logic                             measured,
  output logic                             level_low,
  output logic                             alarm_beep
);

  tds_pkg::cfg_t  cfg;
  tds_pkg::item_t item;
  logic           item_valid;
  logic           core_ready;

  tds_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tds_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .timer_sw_a (timer_sw_a),
    .timer_sw_c (timer_sw_c),
    .qty_sw_a   (qty_sw_a),
    .qty_sw_c   (qty_sw_c),
    .touch_one  (touch_one),
    .touch_two  (touch_two),
    .echo_us    (echo_us),
    .core_ready (core_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  tds_core #(
    .OPEN_LOW_MS    (OPEN_LOW_MS),
    .OPEN_MEDIUM_MS (OPEN_MEDIUM_MS),
    .OPEN_HIGH_MS   (OPEN_HIGH_MS)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .item_valid     (item_valid),
    .item           (item),
    .core_ready     (core_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .dispense_cause (dispense_cause),
    .open_ms        (open_ms),
    .measured       (measured),
    .level_low      (level_low),
    .alarm_beep     (alarm_beep)
  );

endmodule

>>> rtl/tds_cfg_regs.sv
module tds_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tds_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [tds_pkg::CFG_DATA_W-1:0]   cfg_data,
  output tds_pkg::cfg_t                    cfg
);

  logic [tds_pkg::INTERVAL_W-1:0] period_in;
  logic [tds_pkg::SCALED_W-1:0]   thr_in;

  assign period_in = tds_pkg::at_least_one(cfg_data[tds_pkg::INTERVAL_W-1:0]);
  assign thr_in    = tds_pkg::SCALED_W'({14'd0, cfg_data[tds_pkg::THR_W-1:0]}
                     * tds_pkg::SCALED_W'(tds_pkg::DIST_DIV));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_scaled <= tds_pkg::SCALED_W'(tds_pkg::THRESHOLD_RESET * tds_pkg::DIST_DIV);
      cfg.ivl_long         <= tds_pkg::IVL_LONG_RESET;
      cfg.ivl_mid          <= tds_pkg::IVL_MID_RESET;
      cfg.ivl_short        <= tds_pkg::IVL_SHORT_RESET;
      cfg.level_check      <= tds_pkg::LEVEL_CHECK_RESET;
      cfg.alarm_wait       <= tds_pkg::ALARM_WAIT_RESET;
    end else if (cfg_we) begin
      case (tds_pkg::cfg_index_t'(cfg_index))
        tds_pkg::REG_LEVEL_THRESHOLD: cfg.threshold_scaled <= thr_in;
        tds_pkg::REG_IVL_LONG:        cfg.ivl_long         <= period_in;
        tds_pkg::REG_IVL_MID:         cfg.ivl_mid          <= period_in;
        tds_pkg::REG_IVL_SHORT:       cfg.ivl_short        <= period_in;
        tds_pkg::REG_LEVEL_CHECK:     cfg.level_check      <= period_in;
        tds_pkg::REG_ALARM_WAIT:      cfg.alarm_wait       <= period_in;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/tds_in_stage.sv
module tds_in_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        timer_sw_a,
  input  logic                        timer_sw_c,
  input  logic                        qty_sw_a,
  input  logic                        qty_sw_c,
  input  logic                        touch_one,
  input  logic                        touch_two,
  input  logic [tds_pkg::ECHO_W-1:0]  echo_us,
  input  logic                        core_ready,
  output logic                        item_valid,
  output tds_pkg::item_t              item
);

  logic take;

  assign take     = item_valid && core_ready;
  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.timer_a     <= timer_sw_a;
      item.timer_c     <= timer_sw_c;
      item.qty_a       <= qty_sw_a;
      item.qty_c       <= qty_sw_c;
      item.touch       <= touch_one | touch_two;
      item.echo_scaled <= tds_pkg::SCALED_W'({8'd0, echo_us}
                          * tds_pkg::SCALED_W'(tds_pkg::ECHO_SCALE));
    end
  end

endmodule

>>> rtl/tds_core.sv
module tds_core #(
  parameter logic [tds_pkg::OPEN_W-1:0] OPEN_LOW_MS    = tds_pkg::OPEN_LOW_MS,
  parameter logic [tds_pkg::OPEN_W-1:0] OPEN_MEDIUM_MS = tds_pkg::OPEN_MEDIUM_MS,
  parameter logic [tds_pkg::OPEN_W-1:0] OPEN_HIGH_MS   = tds_pkg::OPEN_HIGH_MS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tds_pkg::cfg_t               cfg,
  input  logic                        item_valid,
  input  tds_pkg::item_t              item,
  output logic                        core_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  dispense_cause,
  output logic [tds_pkg::OPEN_W-1:0]  open_ms,
  output logic                        measured,
  output logic                        level_low,
  output logic                        alarm_beep
);

  localparam int unsigned CW = tds_pkg::CNT_W;

  tds_pkg::mode_t       timer_mode, timer_mode_next;
  tds_pkg::mode_t       qty_mode, qty_mode_next;
  logic [CW-1:0]        dispense_elapsed, dispense_elapsed_next;
  logic [CW-1:0]        level_elapsed, level_elapsed_next;
  logic [CW-1:0]        alarm_elapsed, alarm_elapsed_next;
  logic                 food_low, food_low_next;
  logic                 alarm_armed, alarm_armed_next;

  tds_pkg::cause_t             cause;
  logic [tds_pkg::OPEN_W-1:0]  open_len, open_out;
  logic [CW-1:0]               interval, period, wait_len;
  logic [CW-1:0]               d_cnt, l_cnt, a_cnt;
  logic                        meas, beep, armed_mid;
  logic                        take;

  assign core_ready = !out_valid || out_ready;
  assign take       = item_valid && core_ready;

  always_comb begin
    timer_mode_next = timer_mode;
    priority if (item.timer_a && !item.timer_c) timer_mode_next = tds_pkg::MODE_ONE;
    else if (item.timer_a && item.timer_c)      timer_mode_next = tds_pkg::MODE_TWO;
    else if (!item.timer_a && item.timer_c)     timer_mode_next = tds_pkg::MODE_THREE;
    else                                        timer_mode_next = timer_mode;

    qty_mode_next = qty_mode;
    priority if (item.qty_a && !item.qty_c) qty_mode_next = tds_pkg::MODE_THREE;
    else if (item.qty_a && item.qty_c)      qty_mode_next = tds_pkg::MODE_TWO;
    else if (!item.qty_a && item.qty_c)     qty_mode_next = tds_pkg::MODE_ONE;
    else                                    qty_mode_next = qty_mode;

    case (qty_mode_next)
      tds_pkg::MODE_TWO:   open_len = OPEN_MEDIUM_MS;
      tds_pkg::MODE_THREE: open_len = OPEN_HIGH_MS;
      default:             open_len = OPEN_LOW_MS;
    endcase
    case (timer_mode_next)
      tds_pkg::MODE_TWO:   interval = CW'(cfg.ivl_mid);
      tds_pkg::MODE_THREE: interval = CW'(cfg.ivl_short);
      default:             interval = CW'(cfg.ivl_long);
    endcase
    period   = CW'(cfg.level_check);
    wait_len = CW'(cfg.alarm_wait);

    cause    = tds_pkg::CAUSE_NONE;
    open_out = '0;
    d_cnt    = dispense_elapsed;
    l_cnt    = level_elapsed;
    a_cnt    = alarm_elapsed;
    if (item.touch) begin
      cause    = tds_pkg::CAUSE_MANUAL;
      open_out = open_len;
      d_cnt    = '0;
      l_cnt    = '0;
      a_cnt    = '0;
    end

    if (d_cnt >= interval) begin
      cause    = tds_pkg::CAUSE_SCHED;
      open_out = open_len;
      d_cnt    = d_cnt - interval;
    end

    meas          = 1'b0;
    food_low_next = food_low;
    if (l_cnt >= period) begin
      meas          = 1'b1;
      food_low_next = item.echo_scaled >= cfg.threshold_scaled;
      l_cnt         = l_cnt - period;
    end

    beep      = 1'b0;
    armed_mid = alarm_armed && food_low_next;
    if (food_low_next && !armed_mid) begin
      armed_mid = 1'b1;
      a_cnt     = '0;
    end
    alarm_armed_next = armed_mid;
    if (armed_mid && a_cnt >= wait_len) begin
      beep             = 1'b1;
      alarm_armed_next = 1'b0;
      a_cnt            = a_cnt - wait_len;
    end

    dispense_elapsed_next = (&d_cnt) ? d_cnt : d_cnt + CW'(1);
    level_elapsed_next    = (&l_cnt) ? l_cnt : l_cnt + CW'(1);
    alarm_elapsed_next    = (&a_cnt) ? a_cnt : a_cnt + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_mode       <= tds_pkg::MODE_ONE;
      qty_mode         <= tds_pkg::MODE_ONE;
      dispense_elapsed <= '0;
      level_elapsed    <= '0;
      alarm_elapsed    <= '0;
      food_low         <= 1'b0;
      alarm_armed      <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (core_ready) begin
        out_valid <= item_valid;
      end
      if (take) begin
        timer_mode       <= timer_mode_next;
        qty_mode         <= qty_mode_next;
        dispense_elapsed <= dispense_elapsed_next;
        level_elapsed    <= level_elapsed_next;
        alarm_elapsed    <= alarm_elapsed_next;
        food_low         <= food_low_next;
        alarm_armed      <= alarm_armed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dispense_cause <= cause;
      open_ms        <= open_out;
      measured       <= meas;
      level_low      <= food_low_next;
      alarm_beep     <= beep;
    end
  end

  a_beep_needs_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && alarm_beep) |-> level_low)
    else $error("alarm beep without low food level");

  a_open_matches_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((dispense_cause == tds_pkg::CAUSE_NONE) == (open_ms == '0)))
    else $error("open time disagrees with dispense cause");

  a_armed_needs_low: assert property (@(posedge clk) disable iff (rst)
    alarm_armed |-> food_low)
    else $error("alarm armed while food level is sufficient");

  a_cause_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dispense_cause != 2'd3))
    else $error("illegal dispense cause");

endmodule

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tds_pkg::*;

  localparam int unsigned LONG_HOLD    = 60;
  localparam int unsigned PHASE_TICKS  = 110;
  localparam int unsigned RANDOM_PHASES = 8;

  typedef struct packed {
    logic              ta;
    logic              tc;
    logic              qa;
    logic              qc;
    logic              t1;
    logic              t2;
    logic [ECHO_W-1:0] echo;
  } tick_t;

  typedef struct packed {
    cause_t            cause;
    logic [OPEN_W-1:0] open_len;
    logic              measured;
    logic              low;
    logic              beep;
  } feed_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   timer_sw_a = 1'b0;
  logic                   timer_sw_c = 1'b0;
  logic                   qty_sw_a = 1'b0;
  logic                   qty_sw_c = 1'b0;
  logic                   touch_one = 1'b0;
  logic                   touch_two = 1'b0;
  logic [ECHO_W-1:0]      echo_us = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [1:0]             dispense_cause;
  logic [OPEN_W-1:0]      open_ms;
  logic                   measured;
  logic                   level_low;
  logic                   alarm_beep;

  timed_dispense_scheduler_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .timer_sw_a    (timer_sw_a),
    .timer_sw_c    (timer_sw_c),
    .qty_sw_a      (qty_sw_a),
    .qty_sw_c      (qty_sw_c),
    .touch_one     (touch_one),
    .touch_two     (touch_two),
    .echo_us       (echo_us),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .dispense_cause(dispense_cause),
    .open_ms       (open_ms),
    .measured      (measured),
    .level_low     (level_low),
    .alarm_beep    (alarm_beep)
  );

  always #6 clk = ~clk;

  // Shadow of the scheduler's registers and state.
  logic [THR_W-1:0]      thr_cfg;
  logic [INTERVAL_W-1:0] long_cfg, mid_cfg, short_cfg, check_cfg, alarm_cfg;
  mode_t                 timer_mode_q, qty_mode_q;
  logic [31:0]           disp_el, lvl_el, alarm_el;
  logic                  food_low_q, armed_q;

  tick_t       pending_ticks[$];
  feed_t       expected_feeds[$];
  tick_t       cur_tick = '0;
  int unsigned src_gap = 0;
  int unsigned sink_left = 0;
  logic        src_idle = 1'b1;
  logic        sink_idle = 1'b1;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;

  int unsigned mismatch_count = 0;
  int unsigned ticks_done = 0;
  int unsigned results_seen = 0;
  int unsigned settings_done = 0;
  int unsigned n_manual = 0, n_sched = 0, n_measured = 0, n_beep = 0;

  function automatic logic [31:0] nz(logic [INTERVAL_W-1:0] v);
    return (v == '0) ? 32'd1 : 32'(v);
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic feed_t feeder_tick(tick_t t);
    feed_t             r;
    logic [31:0]       ivl;
    logic [31:0]       period;
    logic [31:0]       hold_ms;
    logic [31:0]       distance_cm;
    logic [OPEN_W-1:0] len;
    r = '0;
    r.cause = CAUSE_NONE;
    if (t.ta && !t.tc) timer_mode_q = MODE_ONE;
    else if (t.ta && t.tc) timer_mode_q = MODE_TWO;
    else if (!t.ta && t.tc) timer_mode_q = MODE_THREE;
    if (t.qa && !t.qc) qty_mode_q = MODE_THREE;
    else if (t.qa && t.qc) qty_mode_q = MODE_TWO;
    else if (!t.qa && t.qc) qty_mode_q = MODE_ONE;
    case (qty_mode_q)
      MODE_TWO:   len = OPEN_MEDIUM_MS;
      MODE_THREE: len = OPEN_HIGH_MS;
      default:    len = OPEN_LOW_MS;
    endcase
    case (timer_mode_q)
      MODE_TWO:   ivl = nz(mid_cfg);
      MODE_THREE: ivl = nz(short_cfg);
      default:    ivl = nz(long_cfg);
    endcase
    // A touch restarts every timer, so the schedule cannot fire as well.
    if (t.t1 || t.t2) begin
      r.cause = CAUSE_MANUAL;
      r.open_len = len;
      disp_el = '0;
      lvl_el = '0;
      alarm_el = '0;
    end
    if (disp_el >= ivl) begin
      r.cause = CAUSE_SCHED;
      r.open_len = len;
      disp_el = disp_el - ivl;
    end
    period = nz(check_cfg);
    if (lvl_el >= period) begin
      distance_cm = (32'(t.echo) * ECHO_SCALE) / DIST_DIV;
      r.measured = 1'b1;
      food_low_q = (distance_cm >= 32'(thr_cfg));
      lvl_el = lvl_el - period;
    end
    hold_ms = nz(alarm_cfg);
    if (!food_low_q) armed_q = 1'b0;
    if (food_low_q && !armed_q) begin
      armed_q = 1'b1;
      alarm_el = '0;
    end
    if (armed_q && alarm_el >= hold_ms) begin
      r.beep = 1'b1;
      armed_q = 1'b0;
      alarm_el = alarm_el - hold_ms;
    end
    disp_el = bump(disp_el);
    lvl_el = bump(lvl_el);
    alarm_el = bump(alarm_el);
    r.low = food_low_q;
    return r;
  endfunction

  function automatic int unsigned pick_gap(logic enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("ERROR: result %0d %s got %0d, expected %0d", results_seen, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : driver
    tick_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_feeds.push_back(feeder_tick(cur_tick));
        ticks_done++;
      end
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          nxt = pending_ticks.pop_front();
          cur_tick <= nxt;
          timer_sw_a <= nxt.ta;
          timer_sw_c <= nxt.tc;
          qty_sw_a <= nxt.qa;
          qty_sw_c <= nxt.qc;
          touch_one <= nxt.t1;
          touch_two <= nxt.t2;
          echo_us <= nxt.echo;
          in_valid <= 1'b1;
          src_gap <= pick_gap(src_idle);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    int unsigned gap;
    if (rst) begin
      out_ready <= 1'b0;
      sink_left <= 0;
    end else if (sink_left != 0) begin
      sink_left <= sink_left - 1;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      sink_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      gap = pick_gap(sink_idle);
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        sink_left <= gap - 1;
      end
    end
  end

  always @(posedge clk) begin : monitor
    feed_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_feeds.size() == 0) begin
        report_mismatch("with no tick outstanding", 32'(dispense_cause), 32'd0);
      end else begin
        want = expected_feeds.pop_front();
        if (want.cause == CAUSE_MANUAL) n_manual++;
        if (want.cause == CAUSE_SCHED) n_sched++;
        if (want.measured) n_measured++;
        if (want.beep) n_beep++;
        if (dispense_cause !== want.cause)
          report_mismatch("dispense_cause", 32'(dispense_cause), 32'(want.cause));
        if (open_ms !== want.open_len)
          report_mismatch("open_ms", 32'(open_ms), 32'(want.open_len));
        if (measured !== want.measured)
          report_mismatch("measured", 32'(measured), 32'(want.measured));
        if (level_low !== want.low)
          report_mismatch("level_low", 32'(level_low), 32'(want.low));
        if (alarm_beep !== want.beep)
          report_mismatch("alarm_beep", 32'(alarm_beep), 32'(want.beep));
      end
    end
  end

  task automatic add_tick(logic ta, logic tc, logic qa, logic qc, logic t1, logic t2,
                          logic [ECHO_W-1:0] echo);
    tick_t t;
    t.ta = ta;
    t.tc = tc;
    t.qa = qa;
    t.qc = qc;
    t.t1 = t1;
    t.t2 = t2;
    t.echo = echo;
    pending_ticks.push_back(t);
  endtask

  function automatic tick_t random_tick();
    tick_t       t;
    int unsigned r;
    int          base;
    t = '0;
    if ($urandom_range(0, 1) != 0) begin
      t.ta = 1'($urandom_range(0, 1));
      t.tc = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 1) != 0) begin
      t.qa = 1'($urandom_range(0, 1));
      t.qc = 1'($urandom_range(0, 1));
    end
    r = $urandom_range(0, 99);
    if (r < 8) t.t1 = 1'b1;
    else if (r < 12) t.t2 = 1'b1;
    else if (r < 14) begin
      t.t1 = 1'b1;
      t.t2 = 1'b1;
    end
    // Echo times around the threshold exercise both sides of the comparison.
    base = (int'(thr_cfg) * int'(DIST_DIV) + int'(ECHO_SCALE) - 1) / int'(ECHO_SCALE);
    r = $urandom_range(0, 99);
    if (r < 15) t.echo = '0;
    else if (r < 30) t.echo = '1;
    else if (r < 65 && base <= 65535) begin
      base = base + int'($urandom_range(0, 4)) - 2;
      if (base < 0) base = 0;
      if (base > 65535) base = 65535;
      t.echo = ECHO_W'(base);
    end else t.echo = ECHO_W'($urandom_range(0, 65535));
    return t;
  endfunction

  function automatic logic [INTERVAL_W-1:0] rand_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return INTERVAL_W'(1);
    if (r < 17) return INTERVAL_W'(86400000);
    if (r < 20) return '1;
    return INTERVAL_W'($urandom_range(2, 40));
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
  endtask

  task automatic set_config(logic [THR_W-1:0] thr, logic [INTERVAL_W-1:0] lng,
                            logic [INTERVAL_W-1:0] mid, logic [INTERVAL_W-1:0] sht,
                            logic [INTERVAL_W-1:0] chk, logic [INTERVAL_W-1:0] alm);
    write_reg(REG_LEVEL_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_IVL_LONG, lng);
    write_reg(REG_IVL_MID, mid);
    write_reg(REG_IVL_SHORT, sht);
    write_reg(REG_LEVEL_CHECK, chk);
    write_reg(REG_ALARM_WAIT, alm);
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_cfg = thr;
    long_cfg = lng;
    mid_cfg = mid;
    short_cfg = sht;
    check_cfg = chk;
    alarm_cfg = alm;
    settings_done++;
  endtask

  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid || expected_feeds.size() != 0)
      @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    thr_cfg = THRESHOLD_RESET;
    long_cfg = IVL_LONG_RESET;
    mid_cfg = IVL_MID_RESET;
    short_cfg = IVL_SHORT_RESET;
    check_cfg = LEVEL_CHECK_RESET;
    alarm_cfg = ALARM_WAIT_RESET;
    timer_mode_q = MODE_ONE;
    qty_mode_q = MODE_ONE;
    disp_el = '0;
    lvl_el = '0;
    alarm_el = '0;
    food_low_q = 1'b0;
    armed_q = 1'b0;
    settings_done = 1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Switch decoding and manual keys under the reset settings.
    add_tick(0, 0, 0, 0, 0, 0, 16'h0000);
    add_tick(1, 0, 1, 0, 1, 0, 16'hFFFF);
    add_tick(1, 1, 1, 1, 0, 1, 16'h0000);
    add_tick(0, 1, 0, 1, 1, 1, 16'hFFFF);
    add_tick(0, 0, 0, 0, 1, 0, 16'h0000);
    add_tick(0, 0, 1, 0, 0, 0, 16'h0000);
    drain();

    // Short periods, a threshold that sits exactly on a distance step.
    set_config(10'd16, 27'd3, 27'd2, 27'd1, 27'd1, 27'd2);
    add_tick(1, 0, 1, 0, 0, 0, 16'd970);
    add_tick(0, 0, 0, 0, 0, 0, 16'd969);
    add_tick(0, 0, 0, 0, 0, 0, 16'd970);
    add_tick(1, 1, 1, 1, 0, 0, 16'hFFFF);
    add_tick(0, 0, 0, 0, 0, 0, 16'hFFFF);
    add_tick(0, 0, 0, 0, 0, 0, 16'hFFFF);
    add_tick(0, 0, 0, 0, 0, 0, 16'hFFFF);
    add_tick(0, 1, 0, 1, 0, 0, 16'hFFFF);
    add_tick(0, 0, 0, 0, 1, 0, 16'hFFFF);
    add_tick(0, 0, 0, 0, 0, 1, 16'hFFFF);
    add_tick(0, 0, 0, 0, 0, 0, 16'h0000);
    add_tick(1, 0, 0, 0, 0, 0, 16'h0000);
    add_tick(0, 0, 0, 0, 0, 0, 16'h0000);
    add_tick(0, 0, 0, 0, 0, 0, 16'h0000);
    add_tick(0, 0, 0, 0, 0, 0, 16'h0000);
    add_tick(0, 0, 0, 0, 0, 0, 16'h0000);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config('0, '0, '0, '0, '0, '0);
        1: set_config('1, '1, '1, '1, '1, '1);
        default: set_config(($urandom_range(0, 3) == 0) ? THR_W'($urandom_range(0, 1) * 1023)
                                                        : THR_W'($urandom_range(0, 1023)),
                            rand_period(), rand_period(), rand_period(),
                            rand_period(), rand_period());
      endcase
      src_idle <= (p != 2) && (p != 5);
      sink_idle <= (p != 5);
      if (p == 2) long_hold_req <= 1'b1;
      for (int i = 0; i < PHASE_TICKS; i++) pending_ticks.push_back(random_tick());
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d ticks under %0d register settings, with stalls on both sides.",
             ticks_done, settings_done);
    $display("Saw %0d manual and %0d scheduled dispenses, %0d level checks, %0d beeps.",
             n_manual, n_sched, n_measured, n_beep);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("ERROR: run did not complete in time");
    $display("Mismatches found");
    $finish;
  end

endmodule
